[hw/rtl/ccov_pkg.sv]
// Package: payload types and fixed field widths for the circular arc cover block.
`timescale 1ns / 1ps
package ccov_pkg;

  localparam int FIELD_W = 11;
  localparam logic [FIELD_W-1:0] COUNT_SAT = 11'h7FF;

  typedef struct packed {
    logic               has_arc;
    logic [FIELD_W-1:0] arc_start;
    logic [FIELD_W-1:0] arc_end;
    logic               last;
  } ccov_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] arc_count;
    logic               impossible;
  } ccov_out_t;

endpackage

[hw/rtl/ccov_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ccov_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 24600
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/circular_arc_cover_min_count.sv]
// Top level: minimum circular arc cover via binary lifting over one table RAM.
// An arc item is taken in idle, then each of its raised entries is read and rewritten if the
//   new reach is larger; no new item is taken meanwhile. The item with last=1 then runs the
//   solve: prefix max, top sentinels, lift, walk and check, emit; then a reinit sweep.
// All table accesses share the single RAM port pair: at most one read and one write per cycle.
// Reset (synchronous, rst_n low) clears control, sets position_count to 1024 and starts the
//   level-zero identity sweep over all 2*MAX_POSITIONS+2 entries (no item accepted meanwhile).
`timescale 1ns / 1ps
module circular_arc_cover_min_count
  import ccov_pkg::*;
#(
  parameter int MAX_POSITIONS = 1024,
  parameter int LEVELS        = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ccov_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ccov_out_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // table geometry: LEVELS rows of 2*MAX_POSITIONS+2 entries, row j at base j*TS
  localparam int TS    = 2 * MAX_POSITIONS + 2;
  localparam int VW    = $clog2(TS);
  localparam int DEPTH = LEVELS * TS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(LEVELS);
  localparam int BW    = LEVELS + 1;
  localparam logic [AW-1:0] ROW_STEP = AW'(TS);
  localparam logic [AW-1:0] TOP_BASE = AW'((LEVELS - 1) * TS);
  localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);

  localparam logic [3:0] S_SWEEP   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_RAISE_A = 4'd2;
  localparam logic [3:0] S_RAISE_B = 4'd3;
  localparam logic [3:0] S_PRE_A   = 4'd4;
  localparam logic [3:0] S_PRE_B   = 4'd5;
  localparam logic [3:0] S_TOP     = 4'd6;
  localparam logic [3:0] S_LIFT_A  = 4'd7;
  localparam logic [3:0] S_LIFT_B  = 4'd8;
  localparam logic [3:0] S_LIFT_C  = 4'd9;
  localparam logic [3:0] S_WALK_A  = 4'd10;
  localparam logic [3:0] S_WALK_B  = 4'd11;
  localparam logic [3:0] S_CHK_A   = 4'd12;
  localparam logic [3:0] S_CHK_B   = 4'd13;
  localparam logic [3:0] S_EMIT    = 4'd14;

  localparam logic CFG_IDX_COUNT = 1'b0;

  // ---- registers ----
  logic [3:0]         state_r, state_nxt;
  logic [FIELD_W-1:0] pos_cnt_r, pos_cnt_nxt;
  logic [VW-1:0]      idx_r, idx_nxt;     // sweep / prefix / lift / start index
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic [AW-1:0]      base_r, base_nxt;   // row base of the level being read
  logic [VW-1:0]      prev_r, prev_nxt;   // prefix max carry
  logic [VW-1:0]      x_r, x_nxt;         // walk position
  logic [LEVELS-1:0]  cur_r, cur_nxt;
  logic [BW-1:0]      best_r, best_nxt;
  logic               found_r, found_nxt;
  logic               last_r, last_nxt;
  logic [VW-1:0]      ridx_r [3];
  logic [VW-1:0]      ridx_nxt [3];
  logic [VW-1:0]      rval_r [3];
  logic [VW-1:0]      rval_nxt [3];
  logic [1:0]         rcnt_r, rcnt_nxt;
  logic [1:0]         rpos_r, rpos_nxt;
  logic               out_valid_r, out_valid_nxt;
  ccov_out_t          out_data_r, out_data_nxt;

  // ---- RAM port ----
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;

  ccov_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // ---- derived values ----
  logic [VW-1:0] n_eff, top, goal, m_clamp, l_v, r_v;
  logic          cfg_wr, in_xfer, arc_ok;
  logic [BW-1:0] cand;

  // register value out of range clamps to 1..MAX_POSITIONS
  always_comb begin
    if (pos_cnt_r == '0) begin
      n_eff = VW'(1);
    end else if (32'(pos_cnt_r) > 32'(MAX_POSITIONS)) begin
      n_eff = VW'(MAX_POSITIONS);
    end else begin
      n_eff = VW'(pos_cnt_r);
    end
  end

  assign top     = VW'({n_eff, 1'b1});
  assign goal    = idx_r + n_eff;
  assign m_clamp = (ram_rdata > top) ? top : ram_rdata;
  assign cand    = BW'(cur_r) + BW'(1);

  assign cfg_wr  = cfg_psel & cfg_penable & cfg_pwrite;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid & in_ready;

  // arcs with an endpoint outside 1..n are dropped
  assign arc_ok = in_data.has_arc
                  && (in_data.arc_start != '0) && (32'(in_data.arc_start) <= 32'(n_eff))
                  && (in_data.arc_end != '0) && (32'(in_data.arc_end) <= 32'(n_eff));
  assign l_v = VW'(in_data.arc_start);
  assign r_v = VW'(in_data.arc_end);

  always_comb begin
    state_nxt      = state_r;
    pos_cnt_nxt    = pos_cnt_r;
    idx_nxt        = idx_r;
    lvl_nxt        = lvl_r;
    base_nxt       = base_r;
    prev_nxt       = prev_r;
    x_nxt          = x_r;
    cur_nxt        = cur_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    last_nxt       = last_r;
    ridx_nxt       = ridx_r;
    rval_nxt       = rval_r;
    rcnt_nxt       = rcnt_r;
    rpos_nxt       = rpos_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_SWEEP: begin
        // level zero back to identity
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r);
        ram_wdata = idx_r;
        if (32'(idx_r) == TS - 1) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + VW'(1);
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          last_nxt = in_data.last;
          rpos_nxt = '0;
          if (arc_ok && (l_v <= r_v)) begin
            ridx_nxt[0] = l_v;
            rval_nxt[0] = r_v + VW'(1);
            ridx_nxt[1] = l_v + n_eff;
            rval_nxt[1] = r_v + n_eff + VW'(1);
            rcnt_nxt    = 2'd2;
          end else if (arc_ok) begin
            // wrapping arc: three pieces on the doubled circle
            ridx_nxt[0] = VW'(1);
            rval_nxt[0] = r_v + VW'(1);
            ridx_nxt[1] = l_v;
            rval_nxt[1] = r_v + n_eff + VW'(1);
            ridx_nxt[2] = n_eff + l_v;
            rval_nxt[2] = top;
            rcnt_nxt    = 2'd3;
          end else begin
            rcnt_nxt = 2'd0;
          end
          if (arc_ok) begin
            state_nxt = S_RAISE_A;
          end else if (in_data.last) begin
            state_nxt = S_PRE_A;
            idx_nxt   = VW'(1);
            prev_nxt  = '0;
          end
        end
      end
      S_RAISE_A: begin
        ram_raddr = AW'(ridx_r[rpos_r]);
        state_nxt = S_RAISE_B;
      end
      S_RAISE_B: begin
        if (ram_rdata < rval_r[rpos_r]) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(ridx_r[rpos_r]);
          ram_wdata = rval_r[rpos_r];
        end
        if (rpos_r == rcnt_r - 2'd1) begin
          if (last_r) begin
            state_nxt = S_PRE_A;
            idx_nxt   = VW'(1);
            prev_nxt  = '0;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          rpos_nxt  = rpos_r + 2'd1;
          state_nxt = S_RAISE_A;
        end
      end
      S_PRE_A: begin
        ram_raddr = AW'(idx_r);
        state_nxt = S_PRE_B;
      end
      S_PRE_B: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r);
        ram_wdata = (ram_rdata < prev_r) ? prev_r : ram_rdata;
        prev_nxt  = ram_wdata;
        if (idx_r == top - VW'(1)) begin
          state_nxt = S_TOP;
          lvl_nxt   = '0;
          base_nxt  = '0;
        end else begin
          idx_nxt   = idx_r + VW'(1);
          state_nxt = S_PRE_A;
        end
      end
      S_TOP: begin
        // sentinel column
        ram_we    = 1'b1;
        ram_waddr = base_r + AW'(top);
        ram_wdata = top;
        if (lvl_r == LVL_LAST) begin
          state_nxt = S_LIFT_A;
          idx_nxt   = top - VW'(1);
          lvl_nxt   = LW'(1);
          base_nxt  = '0;
        end else begin
          lvl_nxt  = lvl_r + LW'(1);
          base_nxt = base_r + ROW_STEP;
        end
      end
      S_LIFT_A: begin
        ram_raddr = base_r + AW'(idx_r);
        state_nxt = S_LIFT_B;
      end
      S_LIFT_B: begin
        ram_raddr = base_r + AW'(m_clamp);
        state_nxt = S_LIFT_C;
      end
      S_LIFT_C: begin
        ram_we    = 1'b1;
        ram_waddr = base_r + ROW_STEP + AW'(idx_r);
        ram_wdata = ram_rdata;
        if (lvl_r == LVL_LAST) begin
          if (idx_r == VW'(1)) begin
            state_nxt = S_WALK_A;
            x_nxt     = VW'(1);
            cur_nxt   = '0;
            lvl_nxt   = LVL_LAST;
            base_nxt  = TOP_BASE;
            found_nxt = 1'b0;
          end else begin
            idx_nxt   = idx_r - VW'(1);
            lvl_nxt   = LW'(1);
            base_nxt  = '0;
            state_nxt = S_LIFT_A;
          end
        end else begin
          lvl_nxt   = lvl_r + LW'(1);
          base_nxt  = base_r + ROW_STEP;
          state_nxt = S_LIFT_A;
        end
      end
      S_WALK_A: begin
        ram_raddr = base_r + AW'(x_r);
        state_nxt = S_WALK_B;
      end
      S_WALK_B: begin
        if (m_clamp < goal) begin
          cur_nxt = cur_r | (LEVELS'(1) << lvl_r);
          x_nxt   = m_clamp;
        end
        if (lvl_r == '0) begin
          state_nxt = S_CHK_A;
        end else begin
          lvl_nxt   = lvl_r - LW'(1);
          base_nxt  = base_r - ROW_STEP;
          state_nxt = S_WALK_A;
        end
      end
      S_CHK_A: begin
        ram_raddr = AW'(x_r);
        state_nxt = S_CHK_B;
      end
      S_CHK_B: begin
        if ((ram_rdata >= goal) && (!found_r || (cand < best_r))) begin
          best_nxt  = cand;
          found_nxt = 1'b1;
        end
        if (idx_r == n_eff) begin
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = idx_r + VW'(1);
          x_nxt     = idx_r + VW'(1);
          cur_nxt   = '0;
          lvl_nxt   = LVL_LAST;
          base_nxt  = TOP_BASE;
          state_nxt = S_WALK_A;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            // count saturates at the field maximum
            out_data_nxt.arc_count  = (32'(best_r) > 32'(COUNT_SAT)) ? COUNT_SAT
                                                                      : FIELD_W'(best_r);
            out_data_nxt.impossible = 1'b0;
          end else begin
            out_data_nxt.arc_count  = '0;
            out_data_nxt.impossible = 1'b1;
          end
          state_nxt = S_SWEEP;
          idx_nxt   = '0;
        end
      end
      default: begin
        state_nxt = S_SWEEP;
        idx_nxt   = '0;
      end
    endcase

    // register write drops pending arcs and restarts the problem
    if (cfg_wr && (cfg_paddr[2] == CFG_IDX_COUNT)) begin
      pos_cnt_nxt = cfg_pwdata[FIELD_W-1:0];
      state_nxt   = S_SWEEP;
      idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      idx_r        <= '0;
      pos_cnt_r    <= FIELD_W'(MAX_POSITIONS);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pos_cnt_r    <= pos_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    base_r     <= base_nxt;
    prev_r     <= prev_nxt;
    x_r        <= x_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    found_r    <= found_nxt;
    last_r     <= last_nxt;
    ridx_r     <= ridx_nxt;
    rval_r     <= rval_nxt;
    rcnt_r     <= rcnt_nxt;
    rpos_r     <= rpos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_COUNT) ? {21'b0, pos_cnt_r} : 32'b0;

`ifndef SYNTH
  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (32'(ram_waddr) < DEPTH))
    else $error("table write address beyond depth");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside emit");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK_A) |-> (x_r <= top))
    else $error("walk position past sentinel");
`endif

endmodule

[tb/circular_arc_cover_min_count_tb.sv]
// Testbench for circular_arc_cover_min_count: directed and random arc problems, checked per result.
`timescale 1ns / 1ps
module circular_arc_cover_min_count_tb;
  import ccov_pkg::*;

  localparam int MAXP     = 1024;
  localparam int LVL      = 12;
  localparam int TAB_SZ   = 2 * MAXP + 2;
  // reinit sweep after a result plus margin; arc items produce nothing to wait on
  localparam int SETTLE   = 2 * MAXP + 200;
  // a full n=1024 solve runs with no transfer at all
  localparam int WDOG_MAX = 400000;
  localparam int HOLD_LEN = 3000;
  localparam logic [2:0] REG_POSITION_COUNT = 3'd0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ccov_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ccov_out_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  circular_arc_cover_min_count u_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cover predictor: own copy of the reach table and of position_count.
  // ---------------------------------------------------------------------------
  int unsigned reach_tab [LVL][TAB_SZ];
  logic [10:0] n_reg = 11'd1024;

  ccov_in_t  arc_items   [$];  // items waiting to be offered
  ccov_out_t cover_expect[$];  // predicted results, oldest first
  int        fail_count = 0;

  function automatic int unsigned eff_n();
    if (n_reg == 0) return 1;
    if (n_reg > MAXP) return MAXP;
    return n_reg;
  endfunction

  function automatic void clear_reach();
    for (int i = 0; i < TAB_SZ; i++) reach_tab[0][i] = i;
  endfunction

  function automatic void raise_reach(int unsigned idx, int unsigned v);
    if (idx < TAB_SZ && reach_tab[0][idx] < v) reach_tab[0][idx] = v;
  endfunction

  // fewest arcs covering the circle, or all ones when none does
  function automatic int unsigned min_cover(int unsigned n);
    int unsigned top, prev, best, m, cnt, x, goal;
    top = 2 * n + 1;
    prev = 0;
    best = 32'hFFFF_FFFF;
    for (int unsigned i = 1; i < top; i++) begin
      if (reach_tab[0][i] < prev) reach_tab[0][i] = prev;
      prev = reach_tab[0][i];
    end
    for (int j = 0; j < LVL; j++) reach_tab[j][top] = top;
    for (int unsigned i = top - 1; i >= 1; i--) begin
      for (int j = 1; j < LVL; j++) begin
        m = reach_tab[j-1][i];
        if (m > top) m = top;
        reach_tab[j][i] = reach_tab[j-1][m];
      end
    end
    for (int unsigned i = 1; i <= n; i++) begin
      cnt = 0;
      x = i;
      goal = i + n;
      for (int j = LVL - 1; j >= 0; j--) begin
        m = reach_tab[j][x];
        if (m > top) m = top;
        if (m < goal) begin
          cnt |= (32'd1 << j);
          x = m;
        end
      end
      if (reach_tab[0][x] >= goal && cnt + 1 < best) best = cnt + 1;
    end
    return best;
  endfunction

  function automatic void predict_cover(ccov_in_t it);
    int unsigned n, l, r, best;
    ccov_out_t res;
    n = eff_n();
    l = it.arc_start;
    r = it.arc_end;
    if (it.has_arc && l >= 1 && l <= n && r >= 1 && r <= n) begin
      if (l <= r) begin
        raise_reach(l, r + 1);
        raise_reach(l + n, r + n + 1);
      end else begin
        raise_reach(1, r + 1);
        raise_reach(l, r + n + 1);
        raise_reach(n + l, 2 * n + 1);
      end
    end
    if (it.last) begin
      best = min_cover(n);
      if (best == 32'hFFFF_FFFF) begin
        res.arc_count  = '0;
        res.impossible = 1'b1;
      end else begin
        res.arc_count  = (best > COUNT_SAT) ? COUNT_SAT : best[10:0];
        res.impossible = 1'b0;
      end
      cover_expect.push_back(res);
      clear_reach();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Idle control, shared by driver and monitor
  // ---------------------------------------------------------------------------
  int send_idle_pct = 28;
  int recv_idle_pct = 46;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  bit pkt_go        = 1'b0;

  // Driver: offers queued items; payload stays put until the transfer happens.
  always @(posedge clk) begin
    ccov_in_t nxt;
    if (in_valid && in_ready) predict_cover(in_data);
    if (!in_valid || in_ready) begin
      if (pkt_go && arc_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = arc_items.pop_front();
        in_data  <= nxt;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    ccov_out_t exp_res;
    if (out_valid && out_ready) begin
      if (cover_expect.size() == 0) begin
        $display("%0t: unexpected result count=%0d impossible=%0b",
                 $time, out_data.arc_count, out_data.impossible);
        fail_count++;
      end else begin
        exp_res = cover_expect.pop_front();
        if (out_data.arc_count !== exp_res.arc_count) begin
          $display("%0t: arc_count mismatch expected %0d actual %0d",
                   $time, exp_res.arc_count, out_data.arc_count);
          fail_count++;
        end
        if (out_data.impossible !== exp_res.impossible) begin
          $display("%0t: impossible mismatch expected %0b actual %0b",
                   $time, exp_res.impossible, out_data.impossible);
          fail_count++;
        end
      end
    end
    // long hold-off, counted here, while the sender keeps offering
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_LEN;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles without any transfer on any port.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, cover_expect.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_arc(bit has, int unsigned s, int unsigned e, bit lst);
    ccov_in_t it;
    it.has_arc   = has;
    it.arc_start = s[10:0];
    it.arc_end   = e[10:0];
    it.last      = lst;
    arc_items.push_back(it);
  endfunction

  // sender stops until everything offered has gone through and every result is back
  task automatic drain_all();
    wait (arc_items.size() == 0 && !in_valid && cover_expect.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup, access, register taken at the access edge
  task automatic write_position_count(logic [10:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_POSITION_COUNT;
    cfg_pwdata  <= {21'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    n_reg = v;
    clear_reach();  // a write starts a new problem
  endtask

  // one random problem on the current circle; mostly valid arcs, some noise
  task automatic random_problem(inout int sent);
    int unsigned n, k, s, e;
    n = eff_n();
    k = $urandom_range(1, 10);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(9))
        0: queue_arc(1'b1, $urandom_range(2047), $urandom_range(2047), 1'b0);
        1: queue_arc(1'b0, $urandom_range(2047), $urandom_range(2047), 1'b0);
        default: begin
          s = $urandom_range(1, n);
          e = $urandom_range(1, n);
          queue_arc(1'b1, s, e, 1'b0);
        end
      endcase
    end
    // the closing item may or may not carry an arc
    if ($urandom_range(1))
      queue_arc(1'b1, $urandom_range(1, n), $urandom_range(1, n), 1'b1);
    else
      queue_arc(1'b0, $urandom_range(2047), $urandom_range(2047), 1'b1);
    sent += k + 1;
  endtask

  initial begin
    int sent;
    clear_reach();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    pkt_go = 1'b1;

    // Directed: full-size circle at reset value of the register
    queue_arc(1'b0, 2047, 2047, 1'b0);        // no arc, fields ignored
    queue_arc(1'b1, 1, 512, 1'b0);
    queue_arc(1'b1, 600, 1023, 1'b0);
    queue_arc(1'b1, 513, 600, 1'b0);
    queue_arc(1'b1, 1024, 0, 1'b0);           // end outside the circle
    queue_arc(1'b1, 2047, 5, 1'b0);           // start outside the circle
    queue_arc(1'b1, 1024, 1024, 1'b1);
    drain_all();

    // register above the maximum acts as the maximum; one wrapping arc covers all
    write_position_count(11'd2047);
    queue_arc(1'b1, 1000, 999, 1'b1);
    drain_all();

    // register zero acts as one
    write_position_count(11'd0);
    queue_arc(1'b1, 1, 1, 1'b1);
    queue_arc(1'b0, 0, 0, 1'b1);              // empty problem
    queue_arc(1'b1, 2, 1, 1'b1);              // out of range, answers impossible
    drain_all();

    // arcs left pending, then a write drops them
    write_position_count(11'd3);
    queue_arc(1'b1, 1, 3, 1'b0);
    queue_arc(1'b1, 3, 2, 1'b0);
    drain_all();
    write_position_count(11'd5);
    queue_arc(1'b1, 4, 2, 1'b0);              // wrap
    queue_arc(1'b1, 2, 4, 1'b1);
    drain_all();

    // Random part: small circles mostly, a few medium ones
    sent = 0;
    for (int phase_i = 0; phase_i < 3; phase_i++) begin
      if (phase_i == 1) begin
        send_idle_pct = 46;
        recv_idle_pct = 28;
      end else if (phase_i == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int blk = 0; blk < 4; blk++) begin
        if ($urandom_range(4) == 0)
          write_position_count(11'($urandom_range(13, 64)));
        else
          write_position_count(11'($urandom_range(1, 12)));
        for (int p = 0; p < 10; p++) random_problem(sent);
        if (phase_i == 0 && blk == 1) begin
          hold_requests++;
          for (int p = 0; p < 4; p++) random_problem(sent);
        end
        drain_all();
      end
    end
    // top up to the planned item count
    write_position_count(11'd2);
    while (sent < 1100) random_problem(sent);
    drain_all();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[circular_arc_cover_min_count.f]
hw/rtl/ccov_pkg.sv
hw/rtl/ccov_ram.sv
hw/rtl/circular_arc_cover_min_count.sv
tb/circular_arc_cover_min_count_tb.sv
